// ----- hw/rtl/ebed_pkg.sv -----
// shared types and constants for the encoder and button event detector
package ebed_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_W  = 16;
    localparam int unsigned EV_W   = 3;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd50;
    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd1000;

    // configuration register indexes
    localparam logic CFG_DEBOUNCE   = 1'b0;
    localparam logic CFG_LONG_PRESS = 1'b1;

    typedef enum logic [EV_W-1:0] {
        EV_NONE    = 3'd0,
        EV_CW      = 3'd1,
        EV_CCW     = 3'd2,
        EV_SHORT   = 3'd3,
        EV_RELEASE = 3'd4,
        EV_LONG    = 3'd5
    } event_t;

    typedef struct packed {
        logic              a_level;
        logic              b_level;
        logic              button_level;
        logic [TIME_W-1:0] now_ms;
    } poll_t;

    typedef struct packed {
        logic              prev_a;
        logic              prev_raw;
        logic              accepted;
        logic              armed;
        logic [TIME_W-1:0] press_start;
        logic [TIME_W-1:0] raw_change;
    } det_state_t;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] long_press_ms;
    } det_cfg_t;

endpackage

// ----- hw/rtl/ebed_step.sv -----
// next-state and event logic for one poll
module ebed_step (
    input  ebed_pkg::poll_t      poll,
    input  ebed_pkg::det_state_t cur,
    input  ebed_pkg::det_cfg_t   cfg,
    output ebed_pkg::det_state_t nxt,
    output ebed_pkg::event_t     ev
);
    import ebed_pkg::*;

    logic              raw_chg;
    logic [TIME_W-1:0] stamp;
    logic [TIME_W-1:0] since_change;
    logic [TIME_W-1:0] held;
    logic              settled;
    logic              is_long;

    assign raw_chg      = poll.button_level != cur.prev_raw;
    assign stamp        = raw_chg ? poll.now_ms : cur.raw_change;
    assign since_change = poll.now_ms - stamp;
    assign held         = poll.now_ms - cur.press_start;
    assign settled      = since_change > {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_ms};
    assign is_long      = held >= {{(TIME_W-CFG_W){1'b0}}, cfg.long_press_ms};

    always_comb
    begin
        nxt        = cur;
        nxt.prev_a = poll.a_level;
        ev         = EV_NONE;
        if (poll.a_level != cur.prev_a)
        begin
            // rotation wins, button sample ignored
            ev = (poll.a_level == poll.b_level) ? EV_CW : EV_CCW;
        end
        else
        begin
            nxt.prev_raw   = poll.button_level;
            nxt.raw_change = stamp;
            if (settled && (poll.button_level != cur.accepted))
            begin
                nxt.accepted = poll.button_level;
                if (!poll.button_level)
                begin
                    nxt.armed       = 1'b1;
                    nxt.press_start = poll.now_ms;
                end
                else
                begin
                    nxt.armed = 1'b0;
                    ev = is_long ? EV_RELEASE : EV_SHORT;
                end
            end
            else if (!cur.accepted && cur.armed && is_long)
            begin
                nxt.armed = 1'b0;
                ev        = EV_LONG;
            end
        end
    end

endmodule

// ----- hw/rtl/encoder_button_event_detector.sv -----
// top level of the rotary encoder and push-button event detector
// Usage:
//   Input channel carries one poll per transaction: encoder levels a_level
//   and b_level, button_level (0 pressed) and the millisecond time now_ms.
//   Output channel returns exactly one transaction per poll: event_code
//   (none, clockwise, counter-clockwise, short press, release, long press)
//   and button_stable, the debounced button level after that poll.
//   Both channels use valid/stall; a transaction moves when valid is high
//   and stall is low.
//   A poll accepted into the input register is worked into the result
//   register once that register is empty or being taken, and out_valid
//   rises with the registered result. Throughput is one poll per cycle
//   while out_stall is low; the per-poll work is two 32-bit
//   subtract/compare paths.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more poll; in_stall rises only when both are
//   full.
//   Configuration (debounce_ms index 0, long_press_ms index 1) is written
//   through cfg_write/cfg_index/cfg_data; the user must write it only while
//   no poll is in flight (not enforced). Reset returns the encoder and
//   button history to idle levels, timing registers to 50 ms and 1000 ms.
module encoder_button_event_detector (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        a_level,
    input  logic                        b_level,
    input  logic                        button_level,
    input  logic [ebed_pkg::TIME_W-1:0] now_ms,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ebed_pkg::EV_W-1:0]   event_code,
    output logic                        button_stable,
    input  logic                        cfg_write,
    input  logic                        cfg_index,
    input  logic [ebed_pkg::CFG_W-1:0]  cfg_data
);
    import ebed_pkg::*;

    det_cfg_t   cfg_reg;
    det_state_t state_reg;
    det_state_t state_next;
    poll_t      poll_reg;
    logic       poll_valid_reg;
    logic       out_valid_reg;
    event_t     event_reg;
    event_t     event_next;
    logic       stable_reg;
    logic       advance;
    logic       accept;

    assign advance  = poll_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = poll_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    ebed_step u_step (
        .poll (poll_reg),
        .cur  (state_reg),
        .cfg  (cfg_reg),
        .nxt  (state_next),
        .ev   (event_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms   <= DEBOUNCE_RESET;
            cfg_reg.long_press_ms <= LONG_PRESS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_DEBOUNCE:   cfg_reg.debounce_ms   <= cfg_data;
                CFG_LONG_PRESS: cfg_reg.long_press_ms <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.prev_a      <= 1'b0;
            state_reg.prev_raw    <= 1'b1;
            state_reg.accepted    <= 1'b1;
            state_reg.armed       <= 1'b0;
            state_reg.press_start <= '0;
            state_reg.raw_change  <= '0;
            poll_valid_reg        <= 1'b0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (accept)
            begin
                poll_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                poll_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            poll_reg.a_level      <= a_level;
            poll_reg.b_level      <= b_level;
            poll_reg.button_level <= button_level;
            poll_reg.now_ms       <= now_ms;
        end
        if (advance)
        begin
            event_reg  <= event_next;
            stable_reg <= state_next.accepted;
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_code    = event_reg;
    assign button_stable = stable_reg;

    // a release-type event always leaves the button released
    a_release_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_code == EV_SHORT || event_code == EV_RELEASE)
        |-> button_stable)
        else $error("release event with button still pressed");

    // a long press is only reported while the button is held
    a_long_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_code == EV_LONG) |-> !button_stable)
        else $error("long press with button released");

    // input side only backs up when the result register is full and stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without output backpressure");

    // an unstalled result leaves unless a new one replaces it
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !poll_valid_reg |=> !out_valid)
        else $error("result repeated");

endmodule

// ----- bench/ebed_tb_pkg.sv -----
// scoreboard class that mirrors the encoder and button detector and checks its results
`timescale 1ns / 100ps
package ebed_tb_pkg;

    import ebed_pkg::*;

    typedef struct packed {
        event_t code;
        logic   stable;
    } poll_result_t;

    class detector_mirror;
        logic [CFG_W-1:0]  debounce;
        logic [CFG_W-1:0]  long_limit;
        logic              last_a;
        logic              raw_btn;
        logic              acc_btn;
        logic              rep_btn;
        logic              armed;
        logic [TIME_W-1:0] press_t0;
        logic [TIME_W-1:0] raw_t;
        poll_result_t      due_events[$];
        int unsigned       errors;
        int unsigned       checked;
        int unsigned       seen[6];

        function new();
            debounce   = DEBOUNCE_RESET;
            long_limit = LONG_PRESS_RESET;
            last_a     = 1'b0;
            raw_btn    = 1'b1;
            acc_btn    = 1'b1;
            rep_btn    = 1'b1;
            armed      = 1'b0;
            press_t0   = '0;
            raw_t      = '0;
            errors     = 0;
            checked    = 0;
            foreach (seen[i]) seen[i] = 0;
        endfunction

        function void set_reg(logic idx, logic [CFG_W-1:0] val);
            if (idx == CFG_DEBOUNCE)
                debounce = val;
            else
                long_limit = val;
        endfunction

        function event_t debounce_button(logic btn, logic [TIME_W-1:0] t);
            logic [TIME_W-1:0] since_change;
            logic [TIME_W-1:0] since_press;
            if (btn != raw_btn)
            begin
                raw_t   = t;
                raw_btn = btn;
            end
            since_change = t - raw_t;
            since_press  = t - press_t0;
            if (since_change > {16'd0, debounce})
            begin
                if (btn != acc_btn)
                begin
                    rep_btn = btn;
                    acc_btn = btn;
                    if (!btn)
                    begin
                        armed    = 1'b1;
                        press_t0 = t;
                        return EV_NONE;
                    end
                    armed = 1'b0;
                    return (since_press < {16'd0, long_limit}) ? EV_SHORT : EV_RELEASE;
                end
                rep_btn = btn;
            end
            // held press reports once, then disarms
            if (!rep_btn && armed && since_press >= {16'd0, long_limit})
            begin
                armed = 1'b0;
                return EV_LONG;
            end
            return EV_NONE;
        endfunction

        function void note_poll(logic a, logic b, logic btn, logic [TIME_W-1:0] t);
            poll_result_t r;
            if (a != last_a)
            begin
                // rotation wins, button sample is dropped
                r.code = (a == b) ? EV_CW : EV_CCW;
                last_a = a;
            end
            else
            begin
                r.code = debounce_button(btn, t);
            end
            r.stable = rep_btn;
            due_events.push_back(r);
        endfunction

        function void check_event(logic [EV_W-1:0] code, logic stable);
            poll_result_t r;
            if (due_events.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual event %0d stable %b",
                         $time, code, stable);
                return;
            end
            r = due_events.pop_front();
            checked++;
            if (code !== r.code)
            begin
                errors++;
                $display("%0t: event_code mismatch, expected %0d (%s), actual %0d",
                         $time, r.code, r.code.name(), code);
            end
            if (stable !== r.stable)
            begin
                errors++;
                $display("%0t: button_stable mismatch, expected %b, actual %b",
                         $time, r.stable, stable);
            end
            if (r.code <= EV_LONG)
                seen[r.code]++;
        endfunction

        function void report_leftover();
            if (due_events.size() != 0)
            begin
                errors += due_events.size();
                $display("%0t: %0d results never arrived, expected event %0d first, actual none",
                         $time, due_events.size(), due_events[0].code);
            end
        endfunction
    endclass

endpackage

// ----- bench/tb_top.sv -----
// top-level testbench for the encoder and button event detector
`timescale 1ns / 100ps
module tb_top;

    import ebed_pkg::*;
    import ebed_tb_pkg::*;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                a_level = 1'b0;
    logic                b_level = 1'b0;
    logic                button_level = 1'b1;
    logic [TIME_W-1:0]   now_ms = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [EV_W-1:0]     event_code;
    logic                button_stable;
    logic                cfg_write = 1'b0;
    logic                cfg_index = CFG_DEBOUNCE;
    logic [CFG_W-1:0]    cfg_data = '0;

    detector_mirror      sb = new();
    logic [TIME_W-1:0]   clock_ms = '0;
    logic                enc_a = 1'b0;
    logic                enc_b = 1'b0;
    int unsigned         quad_pos = 0;
    int unsigned         send_idle_pct = 0;
    int unsigned         stall_pct = 0;
    int unsigned         polls_sent = 0;

    encoder_button_event_detector u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .a_level       (a_level),
        .b_level       (b_level),
        .button_level  (button_level),
        .now_ms        (now_ms),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .event_code    (event_code),
        .button_stable (button_stable),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_event(event_code, button_stable);
    end

    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // advance the millisecond clock by dt and hand one poll to the block
    task automatic poll(input logic a, input logic b, input logic btn,
                        input logic [TIME_W-1:0] dt);
        clock_ms = clock_ms + dt;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        a_level      <= a;
        b_level      <= b;
        button_level <= btn;
        now_ms       <= clock_ms;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_poll(a, b, btn, clock_ms);
        polls_sent++;
    endtask

    task automatic drain();
        int unsigned guard;
        guard = 0;
        in_valid <= 1'b0;
        while (sb.due_events.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] db, input logic [CFG_W-1:0] lp,
                              input int unsigned idle, input int unsigned stall);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= CFG_DEBOUNCE;
        cfg_data  <= db;
        @(posedge clk);
        cfg_index <= CFG_LONG_PRESS;
        cfg_data  <= lp;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_reg(CFG_DEBOUNCE, db);
        sb.set_reg(CFG_LONG_PRESS, lp);
        send_idle_pct = idle;
        stall_pct     = stall;
    endtask

    // one quadrature step in either direction, button held at the given level
    task automatic rotate_step(input logic btn);
        quad_pos = $urandom_range(1) ? (quad_pos + 1) % 4 : (quad_pos + 3) % 4;
        case (quad_pos)
            0: {enc_a, enc_b} = 2'b00;
            1: {enc_a, enc_b} = 2'b10;
            2: {enc_a, enc_b} = 2'b11;
            default: {enc_a, enc_b} = 2'b01;
        endcase
        poll(enc_a, enc_b, btn, $urandom_range(0, 5));
    endtask

    // contact chatter that settles at the given level
    task automatic chatter(input logic level);
        int unsigned flips;
        int unsigned k;
        flips = $urandom_range(0, 3);
        for (k = 0; k < flips; k++)
            poll(enc_a, enc_b, (k % 2 == 0) ? level : !level, $urandom_range(0, sb.debounce / 4 + 2));
        poll(enc_a, enc_b, level, $urandom_range(0, 3));
    endtask

    task automatic press_and_release();
        int unsigned dbn;
        int unsigned hold;
        int unsigned n;
        int unsigned k;
        dbn  = sb.debounce;
        hold = dbn + 1 + $urandom_range(0, 2 * sb.long_limit + 4);
        chatter(1'b0);
        n = $urandom_range(2, 6);
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(9) == 0)
                rotate_step(1'b0);
            poll(enc_a, enc_b, 1'b0, hold / n + 1);
        end
        chatter(1'b1);
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++)
            poll(enc_a, enc_b, 1'b1, dbn / n + 1 + $urandom_range(0, 2));
    endtask

    task automatic noise_burst();
        int unsigned n;
        int unsigned k;
        logic [TIME_W-1:0] dt;
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++)
        begin
            case ($urandom_range(3))
                0: dt = $urandom_range(0, 3);
                1: dt = $urandom_range(0, 2 * sb.debounce + 2);
                2: dt = $urandom;
                default: dt = 32'hFFFF_FF00 + $urandom_range(0, 255);
            endcase
            enc_a = $urandom_range(1);
            enc_b = $urandom_range(1);
            quad_pos = {enc_a, enc_b} == 2'b00 ? 0 : {enc_a, enc_b} == 2'b10 ? 1 :
                       {enc_a, enc_b} == 2'b11 ? 2 : 3;
            poll(enc_a, enc_b, $urandom_range(1), dt);
        end
    endtask

    task automatic random_traffic(input int unsigned count);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned k;
        int unsigned steps;
        stop_at = polls_sent + count;
        while (polls_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 25)
            begin
                steps = $urandom_range(1, 4);
                for (k = 0; k < steps; k++)
                    rotate_step(1'b1);
            end
            else if (pick < 75)
                press_and_release();
            else
                noise_burst();
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset timing 50 ms debounce, 1000 ms long press
        poll(1'b1, 1'b1, 1'b1, 0);      // a high on the first poll reads as rotation
        poll(1'b1, 1'b0, 1'b1, 5);      // b alone moving is not a rotation
        poll(1'b0, 1'b1, 1'b0, 5);      // rotation hides the button sample
        poll(1'b0, 1'b1, 1'b0, 60);
        poll(1'b0, 1'b1, 1'b0, 50);     // exactly at the debounce time
        poll(1'b0, 1'b1, 1'b0, 1);      // one past it, press accepted
        poll(1'b0, 1'b1, 1'b0, 999);
        poll(1'b0, 1'b1, 1'b0, 1);      // long press
        poll(1'b0, 1'b1, 1'b0, 500);
        poll(1'b0, 1'b1, 1'b1, 10);
        poll(1'b0, 1'b1, 1'b1, 51);     // release after long
        poll(1'b0, 1'b1, 1'b0, 100);
        poll(1'b0, 1'b1, 1'b0, 51);
        poll(1'b0, 1'b1, 1'b1, 100);
        poll(1'b0, 1'b1, 1'b1, 51);     // short press
        poll(1'b0, 1'b1, 1'b0, 10);
        poll(1'b0, 1'b1, 1'b1, 10);
        poll(1'b0, 1'b1, 1'b0, 10);
        poll(1'b0, 1'b0, 1'b0, 32'hFFFF_FFF0 - clock_ms);
        poll(1'b0, 1'b0, 1'b0, 15);     // counter at all ones
        poll(1'b0, 1'b0, 1'b0, 1);      // counter wraps to zero
        poll(1'b0, 1'b0, 1'b0, 60);
        poll(1'b1, 1'b0, 1'b0, 2);
        poll(1'b1, 1'b1, 1'b1, 2);
        poll(1'b0, 1'b0, 1'b1, 2);
        {enc_a, enc_b} = 2'b00;
        quad_pos = 0;

        set_config(16'd50, 16'd1000, 0, 0);
        random_traffic(160);
        set_config(16'd0, 16'd0, 77, 0);
        random_traffic(160);
        set_config(16'hFFFF, 16'hFFFF, 0, 77);
        random_traffic(160);
        set_config(16'd7, 16'd40, 13, 13);
        random_traffic(160);
        set_config($urandom_range(0, 200), $urandom_range(0, 2000), 0, 0);
        random_traffic(160);

        drain();
        repeat (8) @(posedge clk);
        sb.report_leftover();
        $display("%0d polls over a directed run and five random timing phases, %0d results checked",
                 polls_sent, sb.checked);
        $display("cw %0d, ccw %0d, short %0d, release %0d, long %0d, quiet %0d",
                 sb.seen[EV_CW], sb.seen[EV_CCW], sb.seen[EV_SHORT],
                 sb.seen[EV_RELEASE], sb.seen[EV_LONG], sb.seen[EV_NONE]);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
